// ===== hw/rtl/rotation_matrix_renormalize_core_defines.svh =====
// assertion helpers for the top-level rtl file
`ifndef ROTATION_MATRIX_RENORMALIZE_CORE_DEFINES_SVH
`define ROTATION_MATRIX_RENORMALIZE_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define RMR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define RMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rmr_pkg.sv =====
package rmr_pkg;

    localparam int Q_W       = 32;
    localparam int P_W       = 64;
    localparam int A_W       = 68;
    localparam int FRAC_BITS = 30;
    localparam int N_ENT     = 9;
    localparam int N_DIM     = 3;
    localparam int LATENCY   = 8;

    typedef logic signed [Q_W-1:0] t_q;
    typedef logic signed [P_W-1:0] t_prod;
    typedef logic signed [A_W-1:0] t_acc;

    // column-major: entry index is column * 3 + row
    typedef t_q    t_mat  [N_ENT];
    typedef t_prod t_pmat [N_ENT];
    typedef t_q    t_vec  [N_DIM];

    localparam t_q   Q_MAX      = 32'sh7FFF_FFFF;
    localparam t_q   Q_MIN      = 32'sh8000_0000;
    localparam t_acc ACC_Q_MAX  = 68'sd2147483647;
    localparam t_acc ACC_Q_MIN  = -68'sd2147483648;
    // 1.5 in q2.30
    localparam t_acc ONE_HALF_Q = 68'sd1610612736;
    // rounding bias for a shift by frac_bits + 1 and by frac_bits
    localparam t_acc RND_31     = 68'sd1073741824;
    localparam t_acc RND_30     = 68'sd536870912;

    function automatic t_q sat_q(input t_acc v);
        t_q res;
        if (v > ACC_Q_MAX) begin
            res = Q_MAX;
        end else if (v < ACC_Q_MIN) begin
            res = Q_MIN;
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/rotation_matrix_renormalize_core.sv =====
// channel   direction  handshake              payload
// command   in         start, busy            i_r1c1 .. i_r3c3, signed q2.30
// result    out        o_valid (strobe)       o_r1c1 .. o_r3c3, signed q2.30
//
// a transaction is taken every cycle outside reset; each result passes through
// the multiply/round pairs of the pipeline: squares, factor, scale, dot, update
// synchronous active-low reset clears the valid chain; busy is high only in reset
// results are strobed for one cycle and cannot be held off by the receiver
`include "rotation_matrix_renormalize_core_defines.svh"

module rotation_matrix_renormalize_core import rmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_q   i_r1c1,
    input  t_q   i_r2c1,
    input  t_q   i_r3c1,
    input  t_q   i_r1c2,
    input  t_q   i_r2c2,
    input  t_q   i_r3c2,
    input  t_q   i_r1c3,
    input  t_q   i_r2c3,
    input  t_q   i_r3c3,
    output logic o_valid,
    output t_q   o_r1c1,
    output t_q   o_r2c1,
    output t_q   o_r3c1,
    output t_q   o_r1c2,
    output t_q   o_r2c2,
    output t_q   o_r3c2,
    output t_q   o_r1c3,
    output t_q   o_r2c3,
    output t_q   o_r3c3
);

    logic w_acc;
    t_mat w_x;
    logic w_vld_n;
    t_mat w_y_n;
    logic w_vld_h;
    t_mat w_y_h;
    t_vec w_h;
    t_mat w_m;

    // the pipeline never backs up, so only reset holds off new transactions
    assign busy  = ~i_rst_n;
    assign w_acc = start & ~busy;

    // column-major packing of the command matrix
    assign w_x[0] = i_r1c1;
    assign w_x[1] = i_r2c1;
    assign w_x[2] = i_r3c1;
    assign w_x[3] = i_r1c2;
    assign w_x[4] = i_r2c2;
    assign w_x[5] = i_r3c2;
    assign w_x[6] = i_r1c3;
    assign w_x[7] = i_r2c3;
    assign w_x[8] = i_r3c3;

    // per-column norm correction, four stages
    rmr_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_x     (w_x),
        .o_vld   (w_vld_n),
        .o_y     (w_y_n)
    );

    // half dot products of column pairs, two stages
    rmr_ortho u_ortho (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld_n),
        .i_y     (w_y_n),
        .o_vld   (w_vld_h),
        .o_y     (w_y_h),
        .o_h     (w_h)
    );

    // cross-column correction and final rounding, two stages
    rmr_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld_h),
        .i_y     (w_y_h),
        .i_h     (w_h),
        .o_vld   (o_valid),
        .o_m     (w_m)
    );

    assign o_r1c1 = w_m[0];
    assign o_r2c1 = w_m[1];
    assign o_r3c1 = w_m[2];
    assign o_r1c2 = w_m[3];
    assign o_r2c2 = w_m[4];
    assign o_r3c2 = w_m[5];
    assign o_r1c3 = w_m[6];
    assign o_r2c3 = w_m[7];
    assign o_r3c3 = w_m[8];

    `RMR_ASSERT_IMPL(a_no_spurious, o_valid, $past(w_acc, LATENCY), "result strobe without command")
    `RMR_ASSERT_IMPL(a_no_loss, w_acc, ##LATENCY o_valid, "accepted command produced no result")
    `RMR_ASSERT_IMPL(a_mid_chain, w_vld_h, $past(w_vld_n, 2), "ortho stage valid out of step")
    `RMR_ASSERT_NEXT(a_tail_chain, w_vld_h, ##1 o_valid, "update stage dropped a transaction")

endmodule

// ===== hw/rtl/rmr_norm.sv =====
module rmr_norm import rmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_mat i_x,
    output logic o_vld,
    output t_mat o_y
);

    logic [3:0] r_vld;
    t_pmat      r_sq;
    t_mat       r_x1;
    t_mat       r_x2;
    t_vec       r_f;
    t_vec       n_f;
    t_pmat      r_p;
    t_mat       r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // column factor: round(1.5 - sum of squares / 2)
    always_comb begin
        for (int c = 0; c < N_DIM; c++) begin
            n_f[c] = sat_q(((RND_31 - (t_acc'(r_sq[3*c]) + t_acc'(r_sq[3*c+1])
                     + t_acc'(r_sq[3*c+2]))) >>> (FRAC_BITS + 1)) + ONE_HALF_Q);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < N_ENT; e++) begin
            r_sq[e] <= t_prod'(i_x[e]) * t_prod'(i_x[e]);
        end
        r_x1 <= i_x;
        r_f  <= n_f;
        r_x2 <= r_x1;
        for (int c = 0; c < N_DIM; c++) begin
            for (int r = 0; r < N_DIM; r++) begin
                r_p[3*c+r] <= t_prod'(r_x2[3*c+r]) * t_prod'(r_f[c]);
            end
        end
        for (int e = 0; e < N_ENT; e++) begin
            r_y[e] <= sat_q((t_acc'(r_p[e]) + RND_30) >>> FRAC_BITS);
        end
    end

    assign o_vld = r_vld[3];
    assign o_y   = r_y;

endmodule

// ===== hw/rtl/rmr_ortho.sv =====
module rmr_ortho import rmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_mat i_y,
    output logic o_vld,
    output t_mat o_y,
    output t_vec o_h
);

    logic [1:0] r_vld;
    t_pmat      r_dp;
    t_mat       r_y5;
    t_mat       r_y6;
    t_vec       r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    // pair order: columns 1-2, 1-3, 2-3
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < N_DIM; r++) begin
            r_dp[r]   <= t_prod'(i_y[r])   * t_prod'(i_y[3+r]);
            r_dp[3+r] <= t_prod'(i_y[r])   * t_prod'(i_y[6+r]);
            r_dp[6+r] <= t_prod'(i_y[3+r]) * t_prod'(i_y[6+r]);
        end
        r_y5 <= i_y;
        for (int k = 0; k < N_DIM; k++) begin
            r_h[k] <= sat_q((t_acc'(r_dp[3*k]) + t_acc'(r_dp[3*k+1])
                      + t_acc'(r_dp[3*k+2]) + RND_31) >>> (FRAC_BITS + 1));
        end
        r_y6 <= r_y5;
    end

    assign o_vld = r_vld[1];
    assign o_y   = r_y6;
    assign o_h   = r_h;

endmodule

// ===== hw/rtl/rmr_update.sv =====
module rmr_update import rmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_mat i_y,
    input  t_vec i_h,
    output logic o_vld,
    output t_mat o_m
);

    logic [1:0] r_vld;
    t_pmat      r_pp;
    t_pmat      r_qp;
    t_mat       r_c;
    t_mat       r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    // h[0] = a, h[1] = b, h[2] = g
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < N_DIM; r++) begin
            r_pp[r]   <= t_prod'(i_h[0]) * t_prod'(i_y[3+r]);
            r_qp[r]   <= t_prod'(i_h[1]) * t_prod'(i_y[6+r]);
            r_pp[3+r] <= t_prod'(i_h[0]) * t_prod'(i_y[r]);
            r_qp[3+r] <= t_prod'(i_h[2]) * t_prod'(i_y[6+r]);
            r_pp[6+r] <= t_prod'(i_h[1]) * t_prod'(i_y[r]);
            r_qp[6+r] <= t_prod'(i_h[2]) * t_prod'(i_y[3+r]);
        end
        r_c <= i_y;
        for (int e = 0; e < N_ENT; e++) begin
            r_m[e] <= sat_q(((t_acc'(r_c[e]) <<< FRAC_BITS) - t_acc'(r_pp[e])
                      - t_acc'(r_qp[e]) + RND_30) >>> FRAC_BITS);
        end
    end

    assign o_vld = r_vld[1];
    assign o_m   = r_m;

endmodule
